### hdl/scf_pkg.sv
// ---------------------------------------------------------------------------
// scf_pkg
// Shared types, field widths and helpers for the strong connection filter.
// ---------------------------------------------------------------------------
package scf_pkg;

    // default number of rows held in the neighbour store
    localparam int unsigned ROWS_DEF = 1024;

    // field widths
    localparam int unsigned OP_W      = 2;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned RATIO_W   = 16;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned PROD_W    = VAL_W + FRAC_W;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned S_PAD_W   = S_TDATA_W - 2 * IDX_W - VAL_W;
    localparam int unsigned M_PAD_W   = M_TDATA_W - 2 * IDX_W - VAL_W;

    // store values
    localparam logic [VAL_W-1:0]   ONE_LSB     = 32'h0000_0001;
    localparam logic [VAL_W-1:0]   SAT_MAX     = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]   NEG_MIN     = 32'h8000_0000;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd6554;

    // operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_OBSERVE = 2'd1,
        OP_TEST    = 2'd2
    } t_op;

    // negated value, saturated at the positive maximum
    function automatic logic [VAL_W-1:0] negate_sat(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] n;
        n = (~v) + ONE_LSB;
        if (v == NEG_MIN) begin
            n = SAT_MAX;
        end
        return n;
    endfunction

endpackage

### hdl/scf_store.sv
// ---------------------------------------------------------------------------
// scf_store
// Row neighbour store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module scf_store
    import scf_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEF,
    parameter int unsigned AW   = $clog2(ROWS_DEF)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [VAL_W-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [VAL_W-1:0] o_rd_data_a,
    output logic [VAL_W-1:0] o_rd_data_b
);

    logic [VAL_W-1:0] r_mem [ROWS];
    logic [VAL_W-1:0] r_rd_a;
    logic [VAL_W-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two read ports, registered
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### hdl/strong_connection_filter_core.sv
// Sequence: a clear completes on acceptance; an observe goes on through EXEC,
// where it may write the store; a test goes through EXEC and then CMP.
// EXEC uses the store's registered read and registers the ratio multiply
// ahead of the strength compare in CMP, which waits for a free output register.
// Reset: synchronous, active low; afterwards a clearing pass walks every row
// address and writes one LSB into each entry, and no item is accepted until it ends.
// ---------------------------------------------------------------------------
// strong_connection_filter_core
// Filters matrix entries down to strong off-diagonal connections, keeping
// each row's largest negated neighbour value in a memory.
// ---------------------------------------------------------------------------
module strong_connection_filter_core
    import scf_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: strength_ratio
    input  logic                 i_cfg_wr_en,
    input  logic [RATIO_W-1:0]   i_cfg_wr_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row[9:0], col[19:10], value[51:20]
    input  logic [OP_W-1:0]      s_axis_tuser,  // operation[1:0]
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // weight[31:0], row_out[41:32], col_out[51:42]
    output logic                 m_axis_tuser   // strong_res[0]
);

    localparam int unsigned AW = $clog2(ROWS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CMP
    } t_state;

    t_state             r_state;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;
    logic [RATIO_W-1:0] r_ratio;

    t_op                r_op;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;
    logic [VAL_W-1:0]   r_value;
    logic               r_row_ok;
    logic               r_col_ok;
    logic [PROD_W-1:0]  r_prod;

    logic               r_out_valid;
    logic               r_out_strong;
    logic [VAL_W-1:0]   r_out_weight;
    logic [IDX_W-1:0]   r_out_row;
    logic [IDX_W-1:0]   r_out_col;

    logic               w_accept;
    t_op                w_in_op;
    logic [IDX_W-1:0]   w_in_row;
    logic [IDX_W-1:0]   w_in_col;
    logic [VAL_W-1:0]   w_in_value;
    logic [31:0]        w_row_ext;
    logic [31:0]        w_col_ext;
    logic [31:0]        w_r_row_ext;
    logic               w_row_ok;
    logic               w_col_ok;

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [VAL_W-1:0]   w_wr_data;
    logic [VAL_W-1:0]   w_rd_a;
    logic [VAL_W-1:0]   w_rd_b;

    logic [VAL_W-1:0]   w_mr;
    logic [VAL_W-1:0]   w_mc;
    logic [VAL_W-1:0]   w_min;
    logic [VAL_W:0]     w_neg;
    logic               w_raise;
    logic [VAL_W-1:0]   w_mag;
    logic [PROD_W-1:0]  w_lhs;
    logic               w_strong;
    logic               w_out_free;
    logic               w_out_load;

    // input unpacking
    assign w_in_op    = t_op'(s_axis_tuser);
    assign w_in_row   = s_axis_tdata[IDX_W-1:0];
    assign w_in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_in_value = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // index range checks and store addresses
    assign w_row_ext   = 32'(w_in_row);
    assign w_col_ext   = 32'(w_in_col);
    assign w_r_row_ext = 32'(r_row);
    assign w_row_ok    = w_row_ext < ROWS;
    assign w_col_ok    = w_col_ext < ROWS;

    // store write port: clearing pass, clear operation, observe raise
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_row_ext[AW-1:0];
        w_wr_data = ONE_LSB;
        priority if (r_clr_busy) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
        end else if (w_accept && (w_in_op == OP_CLEAR) && w_row_ok) begin
            w_wr_en   = 1'b1;
        end else if ((r_state == S_EXEC) && (r_op == OP_OBSERVE) && w_raise) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_r_row_ext[AW-1:0];
            w_wr_data = negate_sat(r_value);
        end else begin
            w_wr_en   = 1'b0;
        end
    end

    scf_store #(
        .ROWS (ROWS),
        .AW   (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_row_ext[AW-1:0]),
        .i_rd_addr_b (w_col_ext[AW-1:0]),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    // store values, out-of-range rows read as one LSB
    assign w_mr  = r_row_ok ? w_rd_a : ONE_LSB;
    assign w_mc  = r_col_ok ? w_rd_b : ONE_LSB;
    assign w_min = (w_mr < w_mc) ? w_mr : w_mc;

    // observe: for an off-diagonal entry of an in-range row, raise when the negated value beats the row's store
    assign w_neg   = (~{r_value[VAL_W-1], r_value}) + 33'd1;
    assign w_raise = (r_row != r_col) && r_row_ok
                     && ($signed(w_neg) > $signed({1'b0, w_rd_a}));

    // test: |value| * 2^16 against ratio * weaker store
    assign w_mag    = r_value[VAL_W-1] ? ((~r_value) + ONE_LSB) : r_value;
    assign w_lhs    = {w_mag, {FRAC_W{1'b0}}};
    assign w_strong = (r_row != r_col) && (w_lhs >= r_prod);

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = (r_state == S_CMP) && w_out_free;

    // sequencer, clearing pass, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_ratio     <= RATIO_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ratio <= i_cfg_wr_data;
            end

            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            // result valid: set on a new result, dropped on its transfer
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= w_in_op;
                        r_row    <= w_in_row;
                        r_col    <= w_in_col;
                        r_value  <= w_in_value;
                        r_row_ok <= w_row_ok;
                        r_col_ok <= w_col_ok;
                        if ((w_in_op == OP_OBSERVE) || (w_in_op == OP_TEST)) begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_TEST) begin
                        r_prod  <= PROD_W'(r_ratio) * PROD_W'(w_min);
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CMP: begin
                    if (w_out_free) begin
                        r_out_strong <= w_strong;
                        r_out_weight <= negate_sat(r_value);
                        r_out_row    <= r_row;
                        r_out_col    <= r_col;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_strong;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_col, r_out_row, r_out_weight};

endmodule

### hdl/scf_check.sv
// ---------------------------------------------------------------------------
// scf_check
// Port-level checks on the strong connection filter, bound to the top level.
// ---------------------------------------------------------------------------
module scf_check
    import scf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [OP_W-1:0]      s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a fresh result comes from an earlier test transfer
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
        $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TEST), 3))
        else $error("result without a matching test transfer");

    // the echoed row is the tested row
    a_row_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
        (m_axis_tdata[VAL_W+IDX_W-1:VAL_W] == $past(s_axis_tdata[IDX_W-1:0], 3)))
        else $error("echoed row differs from tested row");

    // a diagonal entry is never strong
    a_diag_weak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
        (m_axis_tdata[VAL_W+IDX_W-1:VAL_W] != m_axis_tdata[VAL_W+2*IDX_W-1:VAL_W+IDX_W]))
        else $error("diagonal entry reported strong");

endmodule

bind strong_connection_filter_core scf_check u_scf_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
